@@ rtl/core/ldr_pkg.sv @@
// Package for the lens distortion remap block: frame defaults, register
// indexes and fixed field widths. No dependencies.
`default_nettype none

package ldr_pkg;

  localparam int DefWidth  = 1024;
  localparam int DefHeight = 512;

  localparam int ColW  = 10;
  localparam int RowW  = 9;
  localparam int PixW  = 8;
  localparam int IdxW  = 8;
  localparam int RegW  = 32;

  // Normalized coordinate divider: 27 quotient bits (Q.24, up to 4.0).
  localparam int DivStages = 27;

  localparam logic [RegW-1:0] FocalReset = 32'h0010_0000;

  typedef enum logic [IdxW-1:0] {
    REG_K1      = 8'd0,
    REG_K2      = 8'd1,
    REG_P1      = 8'd2,
    REG_P2      = 8'd3,
    REG_FOCAL_X = 8'd4,
    REG_FOCAL_Y = 8'd5,
    REG_CENTRE_X = 8'd6,
    REG_CENTRE_Y = 8'd7
  } reg_idx_t;

  typedef enum logic {
    OP_STORE   = 1'b0,
    OP_REQUEST = 1'b1
  } opcode_t;

endpackage

`default_nettype wire

@@ rtl/core/lens_distortion_remap.sv @@
// Lens distortion remap top level: fixed-point radial/tangential remap
// pipeline in front of a frame memory with one write and one read port. Depends on ldr_pkg.
`default_nettype none

// Channel   | Dir | Handshake                 | Content
// s_axis    | in  | s_axis_tvalid/tready      | store or request transaction
// m_axis    | out | m_axis_tvalid/tready      | one result per request
// cfg       | in  | cfg_valid/cfg_ready       | register index + 32-bit data
//
// One transaction per cycle while the output is not stalled; the result is
// registered through 41 register stages: 1 entry, 27 divider,
// 12 arithmetic/address, 1 memory read.
// Stores travel the same pipeline and write the frame at the memory stage,
// so reads and writes hit the memory strictly in input order.
// The whole pipeline advances together; it holds while a result waits.
// Reset clears control state only; the frame memory is not cleared.
module lens_distortion_remap
  import ldr_pkg::*;
#(
  parameter int WIDTH  = DefWidth,
  parameter int HEIGHT = DefHeight
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // s_axis_tdata: column[9:0], row[18:10], pixel_in[26:19], zero fill
  input  wire logic [31:0]      s_axis_tdata,
  // s_axis_tuser: opcode
  input  wire logic             s_axis_tuser,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // m_axis_tdata: out_column[9:0], out_row[18:10], out_pixel[26:19], zero fill
  output logic [31:0]           m_axis_tdata,
  // m_axis_tuser: mapped_inside
  output logic                  m_axis_tuser,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [IdxW-1:0]  cfg_index,
  input  wire logic [RegW-1:0]  cfg_data
);

  localparam int Depth = WIDTH * HEIGHT;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = $clog2(WIDTH);
  localparam int RW    = $clog2(HEIGHT);
  localparam int DS    = DivStages;
  localparam int NS    = DS + 13;          // entry + divider + 12 math stages
  localparam logic signed [42:0] ULim = 43'(WIDTH) <<< 20;
  localparam logic signed [42:0] VLim = 43'(HEIGHT) <<< 20;
  localparam logic [DS-1:0] QMax = DS'(1) << (DS - 1);

  typedef struct packed {
    logic            req;
    logic            wen;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic [PixW-1:0] pix;
    logic [AW-1:0]   waddr;
  } ctl_t;

  // ---------------------------------------------------------------- config
  logic signed [31:0] k1, k2, p1, p2;
  logic [31:0] focal_x, focal_y, centre_x, centre_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      k1 <= '0;
      k2 <= '0;
      p1 <= '0;
      p2 <= '0;
      focal_x  <= FocalReset;
      focal_y  <= FocalReset;
      centre_x <= '0;
      centre_y <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_K1:       k1 <= $signed(cfg_data);
        REG_K2:       k2 <= $signed(cfg_data);
        REG_P1:       p1 <= $signed(cfg_data);
        REG_P2:       p2 <= $signed(cfg_data);
        REG_FOCAL_X:  focal_x  <= cfg_data;
        REG_FOCAL_Y:  focal_y  <= cfg_data;
        REG_CENTRE_X: centre_x <= cfg_data;
        REG_CENTRE_Y: centre_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // In the divider, a zero focal length acts as one LSB.
  logic [31:0] fdiv [2];
  assign fdiv[0] = (focal_x == '0) ? 32'd1 : focal_x;
  assign fdiv[1] = (focal_y == '0) ? 32'd1 : focal_y;

  // --------------------------------------------------------------- control
  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  logic vld [NS];
  ctl_t ctl [NS];

  logic [ColW-1:0] in_col;
  logic [RowW-1:0] in_row;
  ctl_t in_ctl;
  assign in_col = s_axis_tdata[ColW-1:0];
  assign in_row = s_axis_tdata[ColW +: RowW];

  always_comb begin
    in_ctl.req   = (s_axis_tuser == OP_REQUEST);
    in_ctl.wen   = (32'(in_col) < WIDTH) && (32'(in_row) < HEIGHT);
    in_ctl.col   = in_col;
    in_ctl.row   = in_row;
    in_ctl.pix   = s_axis_tdata[ColW+RowW +: PixW];
    in_ctl.waddr = AW'(in_row) * AW'(WIDTH) + AW'(in_col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= s_axis_tvalid;
      for (int i = 1; i < NS; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl[0] <= in_ctl;
      for (int i = 1; i < NS; i++) ctl[i] <= ctl[i-1];
    end
  end

  // ------------------------------------------ normalize: |du| * 2^24 / f
  // Restoring division, one quotient bit per stage; axis 0 is x, 1 is y.
  logic [31:0]   rem [2][DS+1];
  logic [DS-1:0] quo [2][DS+1];
  logic [2:0]    lo  [2][DS+1];
  logic          sgn [2][DS+1];
  logic          ovf [2][DS+1];
  logic signed [27:0] xn [2];

  for (genvar a = 0; a < 2; a++) begin : g_axis
    logic [33:0] pos;
    logic signed [33:0] du;
    logic [32:0] mag;
    logic [31:0] cen;

    assign cen = (a == 0) ? centre_x : centre_y;
    assign pos = (a == 0) ? {4'b0, in_col, 20'b0} : {5'b0, in_row, 20'b0};
    assign du  = $signed(pos) - $signed({2'b0, cen});
    assign mag = du[33] ? 33'(-du) : du[32:0];

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[a][0] <= {2'b0, mag[32:3]};
        quo[a][0] <= '0;
        lo[a][0]  <= mag[2:0];
        sgn[a][0] <= du[33];
        ovf[a][0] <= {2'b0, mag} >= {fdiv[a], 3'b0};
      end
    end

    for (genvar k = 1; k <= DS; k++) begin : g_div
      localparam int B = DS - k;   // quotient bit produced here
      logic        nb;
      logic [32:0] sh;
      logic        ge;
      if (B >= 24) begin : g_lo
        assign nb = lo[a][k-1][B-24];
      end else begin : g_zero
        assign nb = 1'b0;
      end
      assign sh = {rem[a][k-1], nb};
      assign ge = sh >= {1'b0, fdiv[a]};
      always_ff @(posedge clk) begin
        if (adv) begin
          rem[a][k] <= ge ? 32'(sh - {1'b0, fdiv[a]}) : sh[31:0];
          quo[a][k] <= {quo[a][k-1][DS-2:0], ge};
          lo[a][k]  <= lo[a][k-1];
          sgn[a][k] <= sgn[a][k-1];
          ovf[a][k] <= ovf[a][k-1];
        end
      end
    end

    // saturate to 4.0 and apply sign
    logic [DS-1:0] qs;
    assign qs = (ovf[a][DS] || quo[a][DS] > QMax) ? QMax : quo[a][DS];
    always_ff @(posedge clk) begin
      if (adv) xn[a] <= sgn[a][DS] ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
    end
  end

  // ------------------------------------------------- distortion polynomial
  // M1: squares and cross product
  logic signed [55:0] pxx, pyy, pxy;
  logic signed [27:0] x1, y1;
  always_ff @(posedge clk) begin
    if (adv) begin
      pxx <= xn[0] * xn[0];
      pyy <= xn[1] * xn[1];
      pxy <= xn[0] * xn[1];
      x1  <= xn[0];
      y1  <= xn[1];
    end
  end

  // M2: Q.24 rescale, r^2
  logic signed [31:0] xx2, yy2, xy2, r22;
  logic signed [27:0] x2, y2;
  always_ff @(posedge clk) begin
    if (adv) begin
      xx2 <= $signed(pxx[55:24]);
      yy2 <= $signed(pyy[55:24]);
      xy2 <= $signed(pxy[55:24]);
      r22 <= $signed(pxx[55:24]) + $signed(pyy[55:24]);
      x2  <= x1;
      y2  <= y1;
    end
  end

  // M3: coefficient products
  logic signed [63:0] ka3, kb3, t13, t23, t33, t43;
  logic signed [31:0] r23;
  logic signed [27:0] x3, y3;
  always_ff @(posedge clk) begin
    if (adv) begin
      ka3 <= k1 * r22;
      kb3 <= k2 * r22;
      t13 <= p1 * xy2;
      t23 <= p2 * (r22 + (xx2 <<< 1));
      t33 <= p1 * (r22 + (yy2 <<< 1));
      t43 <= p2 * xy2;
      r23 <= r22;
      x3  <= x2;
      y3  <= y2;
    end
  end

  // M4: Q2.30 rescale, tangential terms
  logic signed [33:0] ka4, kb4, tx4, ty4, tx5, ty5, tx6, ty6, tx7, ty7;
  logic signed [31:0] r24;
  logic signed [27:0] x4, y4;
  always_ff @(posedge clk) begin
    if (adv) begin
      ka4 <= $signed(ka3[63:30]);
      kb4 <= $signed(kb3[63:30]);
      tx4 <= ($signed(t13[63:30]) <<< 1) + $signed(t23[63:30]);
      ty4 <= $signed(t33[63:30]) + ($signed(t43[63:30]) <<< 1);
      r24 <= r23;
      x4  <= x3;
      y4  <= y3;
    end
  end

  // M5: second-order radial term
  logic signed [65:0] kr5;
  logic signed [33:0] ka5;
  logic signed [27:0] x5, y5;
  always_ff @(posedge clk) begin
    if (adv) begin
      kr5 <= kb4 * r24;
      ka5 <= ka4;
      tx5 <= tx4;
      ty5 <= ty4;
      x5  <= x4;
      y5  <= y4;
    end
  end

  // M6: radial factor
  logic signed [41:0] fac6;
  logic signed [27:0] x6, y6;
  always_ff @(posedge clk) begin
    if (adv) begin
      fac6 <= 42'sd16777216 + ka5 + $signed(kr5[65:24]);
      tx6  <= tx5;
      ty6  <= ty5;
      x6   <= x5;
      y6   <= y5;
    end
  end

  // M7: coordinate times factor, split into high and low partial products
  logic signed [51:0] xh7, yh7;
  logic signed [46:0] xl7, yl7;
  always_ff @(posedge clk) begin
    if (adv) begin
      xh7 <= x6 * $signed(fac6[41:18]);
      yh7 <= y6 * $signed(fac6[41:18]);
      xl7 <= x6 * $signed({1'b0, fac6[17:0]});
      yl7 <= y6 * $signed({1'b0, fac6[17:0]});
      tx7 <= tx6;
      ty7 <= ty6;
    end
  end

  // M8: combine, add tangential term, saturate to 32 bits
  logic signed [69:0] xs8, ys8;
  logic signed [47:0] xf8, yf8;
  logic signed [31:0] xd8, yd8;
  assign xs8 = (70'(xh7) <<< 18) + 70'(xl7);
  assign ys8 = (70'(yh7) <<< 18) + 70'(yl7);
  assign xf8 = $signed(xs8[69:24]) + tx7;
  assign yf8 = $signed(ys8[69:24]) + ty7;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sh0000_7FFF_FFFF)       r = 32'sh7FFF_FFFF;
    else if (v < -48'sh0000_8000_0000) r = -32'sh8000_0000;
    else                               r = v[31:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      xd8 <= sat32(xf8);
      yd8 <= sat32(yf8);
    end
  end

  // M9: back to pixels
  logic signed [64:0] pu9, pv9;
  always_ff @(posedge clk) begin
    if (adv) begin
      pu9 <= $signed({1'b0, focal_x}) * xd8;
      pv9 <= $signed({1'b0, focal_y}) * yd8;
    end
  end

  // M10: add principal point, frame check
  logic signed [42:0] pu10, pv10;
  assign pu10 = $signed(pu9[64:24]) + $signed({11'b0, centre_x});
  assign pv10 = $signed(pv9[64:24]) + $signed({11'b0, centre_y});

  logic in11;
  logic [CW-1:0] sc11;
  logic [RW-1:0] sr11;
  always_ff @(posedge clk) begin
    if (adv) begin
      in11 <= !pu10[42] && pu10 < ULim && !pv10[42] && pv10 < VLim;
      sc11 <= pu10[20 +: CW];
      sr11 <= pv10[20 +: RW];
    end
  end

  // M11: frame address
  logic [AW-1:0] raddr;
  logic in12;
  always_ff @(posedge clk) begin
    if (adv) begin
      raddr <= AW'(sr11) * AW'(WIDTH) + AW'(sc11);
      in12  <= in11;
    end
  end

  // ------------------------------------------------------- frame memory
  logic [PixW-1:0] frame [Depth];
  logic [PixW-1:0] rd;
  ctl_t oc;
  logic map_hit;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (vld[NS-1] && !ctl[NS-1].req && ctl[NS-1].wen)
        frame[ctl[NS-1].waddr] <= ctl[NS-1].pix;
      rd      <= frame[raddr];
      oc      <= ctl[NS-1];
      map_hit <= in12;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (adv) m_axis_tvalid <= vld[NS-1] && ctl[NS-1].req;
  end

  assign m_axis_tdata = {5'b0, (map_hit ? rd : '0), oc.row, oc.col};
  assign m_axis_tuser = map_hit;

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Testbench for lens_distortion_remap: random and directed stores/requests,
// checked against a fixed-point remap predictor. Depends on ldr_pkg and the RTL.
`default_nettype none

module tb_top;
  import ldr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FrameW    = DefWidth;
  localparam int FrameH    = DefHeight;
  localparam int PipeDepth = 40;        // pipeline depth margin for drain waits
  localparam int CycleLimit = 600000;
  localparam logic [IdxW-1:0] RegUnused = 8'hFF;

  // Predictor of the remap pipeline plus the queue of expected results.
  class remap_scoreboard;
    logic [PixW-1:0] frame[FrameW*FrameH];
    bit              written[FrameW*FrameH];
    longint          k1, k2, p1, p2;
    longint          fx, fy, cx, cy;
    logic [31:0]     exp_data[$];
    logic            exp_inside[$];
    int              errors;

    function new();
      k1 = 0; k2 = 0; p1 = 0; p2 = 0;
      fx = FocalReset; fy = FocalReset; cx = 0; cy = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [IdxW-1:0] idx, logic [RegW-1:0] d);
      case (idx)
        REG_K1:       k1 = longint'($signed(d));
        REG_K2:       k2 = longint'($signed(d));
        REG_P1:       p1 = longint'($signed(d));
        REG_P2:       p2 = longint'($signed(d));
        REG_FOCAL_X:  fx = longint'({32'd0, d});
        REG_FOCAL_Y:  fy = longint'({32'd0, d});
        REG_CENTRE_X: cx = longint'({32'd0, d});
        REG_CENTRE_Y: cy = longint'({32'd0, d});
        default: ;  // unknown index has no effect
      endcase
    endfunction

    // Pixel coordinate to normalized Q.24, saturated at +-4.0.
    function longint norm(longint pix, longint centre, longint focal);
      longint q;
      q = ((pix <<< 20) - centre) * (64'sd1 <<< 24) / (focal == 0 ? 64'sd1 : focal);
      if (q > (64'sd1 <<< 26)) q = 64'sd1 <<< 26;
      if (q < -(64'sd1 <<< 26)) q = -(64'sd1 <<< 26);
      return q;
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Distort (col,row); >>> on longint floors, as the block's shifts do.
    function void remap(input logic [ColW-1:0] c, input logic [RowW-1:0] r,
                        output bit ins, output int idx);
      longint x, y, xx, yy, xy, r2, fac, xd, yd, pu, pv;
      x  = norm(longint'(c), cx, fx);
      y  = norm(longint'(r), cy, fy);
      xx = (x * x) >>> 24;
      yy = (y * y) >>> 24;
      xy = (x * y) >>> 24;
      r2 = xx + yy;
      fac = (64'sd1 <<< 24) + ((k1 * r2) >>> 30) + ((((k2 * r2) >>> 30) * r2) >>> 24);
      xd = ((x * fac) >>> 24) + 2 * ((p1 * xy) >>> 30) + ((p2 * (r2 + 2 * xx)) >>> 30);
      yd = ((y * fac) >>> 24) + ((p1 * (r2 + 2 * yy)) >>> 30) + 2 * ((p2 * xy) >>> 30);
      xd = sat32(xd);
      yd = sat32(yd);
      pu = ((fx * xd) >>> 24) + cx;
      pv = ((fy * yd) >>> 24) + cy;
      ins = pu >= 0 && pu < (longint'(FrameW) <<< 20) &&
            pv >= 0 && pv < (longint'(FrameH) <<< 20);
      idx = ins ? int'((pv >>> 20) * FrameW + (pu >>> 20)) : 0;
    endfunction

    // Accepted input transaction: update the frame or queue a result.
    function void note_input(opcode_t op, logic [ColW-1:0] c, logic [RowW-1:0] r,
                             logic [PixW-1:0] pix);
      bit ins;
      int idx;
      if (op == OP_STORE) begin
        if (c < FrameW && r < FrameH) begin
          frame[r * FrameW + c] = pix;
          written[r * FrameW + c] = 1'b1;
        end
      end else begin
        remap(c, r, ins, idx);
        exp_data.push_back({5'd0, (ins ? frame[idx] : 8'd0), r, c});
        exp_inside.push_back(ins);
      end
    endfunction

    // Accepted output transaction against the oldest expectation.
    function void check_result(logic [31:0] d, logic ins);
      logic [31:0] ed;
      logic        ei;
      if (exp_data.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result tdata=%h tuser=%b", d, ins);
        return;
      end
      ed = exp_data.pop_front();
      ei = exp_inside.pop_front();
      if (d !== ed || ins !== ei) begin
        errors++;
        if (errors <= 10)
          $display("mismatch col %0d/%0d row %0d/%0d pix %0d/%0d inside %b/%b (exp/act)",
                   ed[9:0], d[9:0], ed[18:10], d[18:10], ed[26:19], d[26:19], ei, ins);
      end
    endfunction

    function int pending();
      return exp_data.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic [31:0] s_axis_tdata;
  logic s_axis_tuser, s_axis_tvalid, s_axis_tready;
  logic [31:0] m_axis_tdata;
  logic m_axis_tuser, m_axis_tvalid, m_axis_tready;
  logic cfg_valid, cfg_ready;
  logic [IdxW-1:0] cfg_index;
  logic [RegW-1:0] cfg_data;

  remap_scoreboard sb = new();
  int  send_idle_pct = 0;   // sender gap probability, percent
  int  recv_stall_pct = 0;  // receiver stall probability, percent
  int  hold_req = 0;        // long receiver hold-off request, in cycles
  int  cycles = 0;

  always #2ns clk = ~clk;

  lens_distortion_remap u_top (
    .clk, .rst,
    .s_axis_tdata, .s_axis_tuser, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tuser, .m_axis_tvalid, .m_axis_tready,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Result side: check each output transaction, then pick next tready.
  // A hold-off request keeps tready low for a counted stretch.
  int hold_left = 0;
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // One input transaction, with random gaps in front of it.
  task automatic send(opcode_t op, logic [ColW-1:0] c, logic [RowW-1:0] r,
                      logic [PixW-1:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'd0, pix, r, c};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(op, c, r, pix);
  endtask

  // Request; a mapped pixel never stored gets a store first so that no
  // unwritten frame entry is ever read.
  task automatic request(logic [ColW-1:0] c, logic [RowW-1:0] r);
    bit ins;
    int idx;
    sb.remap(c, r, ins, idx);
    if (ins && !sb.written[idx])
      send(OP_STORE, ColW'(idx % FrameW), RowW'(idx / FrameW), PixW'($urandom));
    send(OP_REQUEST, c, r, PixW'($urandom));
  endtask

  // Stop offering and wait until every result is back, plus the pipeline
  // depth so that trailing stores have reached the frame.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PipeDepth + 4) @(posedge clk);
  endtask

  // Leaves cfg_valid high so that writes can follow back to back.
  task automatic cfg_write(logic [IdxW-1:0] idx, logic [RegW-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, d);
  endtask

  task automatic cfg_all(logic [31:0] k1, logic [31:0] k2, logic [31:0] p1,
                         logic [31:0] p2, logic [31:0] fx, logic [31:0] fy,
                         logic [31:0] cx, logic [31:0] cy);
    cfg_write(REG_K1, k1);
    cfg_write(REG_K2, k2);
    cfg_write(REG_P1, p1);
    cfg_write(REG_P2, p2);
    cfg_write(REG_FOCAL_X, fx);
    cfg_write(REG_FOCAL_Y, fy);
    cfg_write(REG_CENTRE_X, cx);
    cfg_write(REG_CENTRE_Y, cy);
    cfg_valid <= 1'b0;
  endtask

  // Mostly requests over the whole field range, with stores mixed in.
  task automatic random_items(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0)
        send(OP_STORE, ColW'($urandom), RowW'($urandom), PixW'($urandom));
      else
        request(ColW'($urandom), RowW'($urandom));
    end
  endtask

  // Idle profile per phase: none, sender, receiver, both.
  task automatic set_idling(int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
      default: begin send_idle_pct = 30; recv_stall_pct = 30; end
    endcase
  endtask

  initial begin
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= OP_STORE;
    s_axis_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings (unit focal, zero centre), field extremes.
    send(OP_STORE, 10'd0, 9'd0, 8'd0);
    send(OP_STORE, 10'd1023, 9'd511, 8'd255);
    send(OP_STORE, 10'd4, 9'd4, 8'hA5);
    request(10'd0, 9'd0);
    request(10'd1023, 9'd511);
    request(10'd1023, 9'd0);
    request(10'd0, 9'd511);
    request(10'd1, 9'd1);
    drain();

    // Zero focal length is used as one LSB in the divide; unknown index is ignored.
    cfg_write(RegUnused, 32'hDEAD_BEEF);
    cfg_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    request(10'd0, 9'd0);
    request(10'd512, 9'd256);
    drain();

    // Extreme coefficients and focal lengths, centre at its maximum value.
    cfg_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    request(10'd0, 9'd0);
    request(10'd1023, 9'd511);
    request(10'd511, 9'd255);
    drain();
    cfg_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'd1, 32'd1, 32'd0, 32'd0);
    request(10'd3, 9'd7);
    request(10'd1023, 9'd511);
    drain();

    // Random phases across lens settings.
    for (int ph = 0; ph < 6; ph++) begin
      set_idling(ph);
      case (ph)
        0: cfg_all(-32'sd304307145, 32'd79412950, 32'd207866, 32'd18918,
                   32'd480933577, 32'd479509610, 32'd385052835, 32'd260440064);
        1: cfg_all(32'd0, 32'd0, 32'd0, 32'd0,
                   32'd400 << 20, 32'd400 << 20, 32'd512 << 20, 32'd256 << 20);
        2: cfg_all($urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom);
        3: cfg_all(32'h0400_0000, 32'hFC00_0000, 32'h0010_0000, 32'hFFF0_0000,
                   32'd300 << 20, 32'd250 << 20, 32'd500 << 20, 32'd260 << 20);
        4: cfg_all(32'hC000_0000, 32'h1000_0000, 32'd0, 32'd0,
                   32'd800 << 20, 32'd600 << 20, 32'd512 << 20, 32'd256 << 20);
        default: cfg_all(-32'sd304307145, 32'd79412950, 32'd207866, 32'd18918,
                         32'd480933577, 32'd479509610, 32'd385052835, 32'd260440064);
      endcase
      // Long receiver hold-off while the sender keeps going.
      if (ph == 1) hold_req = 300;
      random_items(100);
      drain();
    end

    set_idling(0);
    repeat (PipeDepth + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end
endmodule

`default_nettype wire
